@@ hw/rtl/nclab_pkg.sv @@
// Shared types and constants of the nearest-center pixel labeler.
package nclab_pkg;

   localparam int COORD_W    = 32;
   localparam int CENTER_W   = COORD_W + 1;
   localparam int PIX_W      = 12;
   localparam int SIZE_W     = 24;
   localparam int PROD_W     = PIX_W + SIZE_W;
   localparam int MAP_W      = PROD_W + 2;
   localparam int DIFF_W     = MAP_W + 2;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int DIST_W     = SQ_W + 1;
   localparam int SLOT_W     = 4;
   localparam int LABEL_W    = 5;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // 30.0 map units, used when pixel_size is written as zero
   localparam logic [SIZE_W-1:0] DEFAULT_PIXEL_SIZE = 24'd480;

   typedef enum logic [0:0] {
      CMD_LOAD  = 1'b0,
      CMD_LABEL = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_COUNT = 2'd0,
      CSR_ORIGIN_X    = 2'd1,
      CSR_TOP_Y       = 2'd2,
      CSR_PIXEL_SIZE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SLOT_W-1:0]         entry_index;
      logic signed [COORD_W-1:0] box_left;
      logic signed [COORD_W-1:0] box_bottom;
      logic signed [COORD_W-1:0] box_right;
      logic signed [COORD_W-1:0] box_top;
      logic [PIX_W-1:0]          column;
      logic [PIX_W-1:0]          row;
   } req_data_type;

   // Normalized box plus doubled center
   typedef struct packed {
      logic signed [COORD_W-1:0]  left;
      logic signed [COORD_W-1:0]  bottom;
      logic signed [COORD_W-1:0]  right;
      logic signed [COORD_W-1:0]  top;
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_y;
   } entry_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] top_y;
      logic [SIZE_W-1:0]         pixel_size;
   } cfg_type;

   typedef struct packed {
      logic tbl_we;
      logic pix_load;
      logic mul_en;
      logic add_en;
      logic scan_clear;
      logic rd_en;
      logic out_load;
      logic out_zero;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic raster_miss;
   } dp_status_type;

endpackage

@@ hw/rtl/nclab_req_if.sv @@
// Request channel: load and label commands.
interface nclab_req_if;
   import nclab_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [0:0]                command;
   logic [SLOT_W-1:0]         entry_index;
   logic signed [COORD_W-1:0] box_left;
   logic signed [COORD_W-1:0] box_bottom;
   logic signed [COORD_W-1:0] box_right;
   logic signed [COORD_W-1:0] box_top;
   logic [PIX_W-1:0]          column;
   logic [PIX_W-1:0]          row;

   modport source (
      output valid, command, entry_index, box_left, box_bottom, box_right, box_top,
             column, row,
      input  ready
   );
   modport sink (
      input  valid, command, entry_index, box_left, box_bottom, box_right, box_top,
             column, row,
      output ready
   );
endinterface

@@ hw/rtl/nclab_rsp_if.sv @@
// Response channel: one label per request.
interface nclab_rsp_if;
   import nclab_pkg::*;

   logic               valid;
   logic               ready;
   logic [LABEL_W-1:0] label;

   modport source (output valid, label, input ready);
   modport sink (input valid, label, output ready);
endinterface

@@ hw/rtl/nclab_csr_if.sv @@
// Configuration write channel.
interface nclab_csr_if;
   import nclab_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/nclab_ctrl.sv @@
// Controller state machine of the pixel labeler.
module nclab_ctrl #(
   parameter int  MAX_IMAGES = 16,
   localparam int IDX_W      = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1,
   localparam int CNT_W      = $clog2(MAX_IMAGES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [0:0]               req_command,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [CNT_W-1:0]         count,
   input  nclab_pkg::dp_status_type status,
   output nclab_pkg::ctrl_cmd_type  cmd,
   output logic [IDX_W-1:0]         rd_addr
);
   import nclab_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             is_load_ff, is_load_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      is_load_in   = is_load_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  cmd.tbl_we = 1'b1;
                  is_load_in = 1'b1;
                  state_in   = ST_RESP;
               end else begin
                  cmd.pix_load = 1'b1;
                  is_load_in   = 1'b0;
                  state_in     = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul_en     = 1'b1;
            cmd.scan_clear = 1'b1;
            if (status.raster_miss || (count == '0)) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_en = 1'b1;
            idx_in     = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            idx_in    = idx_ff + CNT_W'(1);
            if (idx_in == count) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_zero = is_load_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         is_load_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         is_load_ff   <= is_load_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rd_addr   = idx_ff[IDX_W-1:0];

endmodule

@@ hw/rtl/nclab_dp.sv @@
// Datapath of the pixel labeler: footprint table, mapping and scan pipeline.
module nclab_dp #(
   parameter int  MAX_IMAGES = 16,
   parameter int  MAX_SIDE   = 4096,
   localparam int IDX_W      = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nclab_pkg::ctrl_cmd_type             cmd,
   output nclab_pkg::dp_status_type            status,
   input  logic [IDX_W-1:0]                    rd_addr,
   input  nclab_pkg::req_data_type             req_data,
   input  nclab_pkg::cfg_type                  cfg,
   output logic [nclab_pkg::LABEL_W-1:0]       label
);
   import nclab_pkg::*;

   entry_type table_mem [MAX_IMAGES];

   entry_type  new_entry;
   logic       slot_ok;
   logic [IDX_W-1:0] wr_addr;

   logic [PIX_W-1:0]         col_ff, row_ff;
   logic [PROD_W-1:0]        px_ff, py_ff;
   logic signed [MAP_W-1:0]  x_ff, y_ff;

   // scan pipeline: read, test, square, compare
   entry_type                a_ent_ff;
   logic                     a_valid_ff;
   logic [IDX_W-1:0]         a_idx_ff;
   logic                     b_valid_ff;
   logic [IDX_W-1:0]         b_idx_ff;
   logic signed [CENTER_W-1:0] dx_ff, dy_ff;
   logic                     c_valid_ff;
   logic [IDX_W-1:0]         c_idx_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic                     found_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [DIST_W-1:0]        best_dist_ff;
   logic [LABEL_W-1:0]       label_ff;

   logic                       in_box;
   logic signed [DIFF_W-1:0]   dx_full, dy_full;
   logic signed [2*CENTER_W-1:0] sqx_full, sqy_full;
   logic [DIST_W-1:0]          sum_sq;
   logic                       better;

   // Normalize the incoming box and precompute its doubled center
   always_comb begin
      if (req_data.box_left < req_data.box_right) begin
         new_entry.left  = req_data.box_left;
         new_entry.right = req_data.box_right;
      end else begin
         new_entry.left  = req_data.box_right;
         new_entry.right = req_data.box_left;
      end
      if (req_data.box_bottom < req_data.box_top) begin
         new_entry.bottom = req_data.box_bottom;
         new_entry.top    = req_data.box_top;
      end else begin
         new_entry.bottom = req_data.box_top;
         new_entry.top    = req_data.box_bottom;
      end
      new_entry.center_x = CENTER_W'(req_data.box_left) + CENTER_W'(req_data.box_right);
      new_entry.center_y = CENTER_W'(req_data.box_bottom) + CENTER_W'(req_data.box_top);
   end

   assign slot_ok = int'(req_data.entry_index) < MAX_IMAGES;
   assign wr_addr = IDX_W'(req_data.entry_index);

   always_ff @(posedge clock) begin
      if (cmd.tbl_we && slot_ok) begin
         table_mem[wr_addr] <= new_entry;
      end
      if (cmd.rd_en) begin
         a_ent_ff <= table_mem[rd_addr];
      end
   end

   // Box test and doubled offsets from the center
   always_comb begin
      in_box = (x_ff >= MAP_W'(a_ent_ff.left))   && (x_ff <= MAP_W'(a_ent_ff.right)) &&
               (y_ff >= MAP_W'(a_ent_ff.bottom)) && (y_ff <= MAP_W'(a_ent_ff.top));
      dx_full = (DIFF_W'(x_ff) <<< 1) - DIFF_W'(a_ent_ff.center_x);
      dy_full = (DIFF_W'(y_ff) <<< 1) - DIFF_W'(a_ent_ff.center_y);
   end

   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;
   assign sum_sq   = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   assign better   = !found_ff || (sum_sq < best_dist_ff);

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.pix_load) begin
         col_ff <= req_data.column;
         row_ff <= req_data.row;
      end
      if (cmd.mul_en) begin
         px_ff <= PROD_W'(col_ff) * PROD_W'(cfg.pixel_size);
         py_ff <= PROD_W'(row_ff) * PROD_W'(cfg.pixel_size);
      end
      if (cmd.add_en) begin
         x_ff <= MAP_W'(cfg.origin_x) + $signed(MAP_W'(px_ff));
         y_ff <= MAP_W'(cfg.top_y) - $signed(MAP_W'(py_ff));
      end
      a_idx_ff <= rd_addr;
      b_idx_ff <= a_idx_ff;
      dx_ff    <= dx_full[CENTER_W-1:0];
      dy_ff    <= dy_full[CENTER_W-1:0];
      c_idx_ff <= b_idx_ff;
      sqx_ff   <= sqx_full[SQ_W-1:0];
      sqy_ff   <= sqy_full[SQ_W-1:0];
      if (c_valid_ff && better) begin
         best_idx_ff  <= c_idx_ff;
         best_dist_ff <= sum_sq;
      end
      if (cmd.out_load) begin
         if (cmd.out_zero || !found_ff) begin
            label_ff <= '0;
         end else begin
            label_ff <= LABEL_W'(best_idx_ff) + LABEL_W'(1);
         end
      end
   end

   // Pipeline valid bits and the found flag
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         a_valid_ff <= cmd.rd_en;
         b_valid_ff <= a_valid_ff && in_box;
         c_valid_ff <= b_valid_ff;
         if (cmd.scan_clear) begin
            found_ff <= 1'b0;
         end else if (c_valid_ff) begin
            found_ff <= 1'b1;
         end
      end
   end

   assign status.pipe_busy   = a_valid_ff || b_valid_ff || c_valid_ff;
   assign status.raster_miss = (int'(col_ff) >= MAX_SIDE) || (int'(row_ff) >= MAX_SIDE);
   assign label              = label_ff;

endmodule

@@ hw/rtl/nearest_center_pixel_labeler.sv @@
// Top level of the nearest-center pixel labeler.
//
// A load request writes one footprint box into slot entry_index of an internal
// table (the box is stored with its corners sorted) and returns label 0; slots
// at or beyond MAX_IMAGES are ignored. A label request maps (column, row) to
// the map point x = origin_x + column*pixel_size, y = top_y - row*pixel_size,
// checks the first image_count boxes (saturated to MAX_IMAGES) for containment
// with inclusive bounds, and returns one plus the index of the containing box
// whose center lies nearest by squared distance, the lower index on a tie, or
// 0 when no box contains the point or the pixel lies outside MAX_SIDE. Every
// request yields exactly one response. The table has a single read port, and
// a label scan examines one entry per cycle through a four-stage
// read/test/square/compare pipeline; a label with an empty search or an
// off-raster pixel skips the scan. The response sits in an output register,
// so the controller takes the next request while an earlier label still
// waits on rsp_chan. Configuration writes are always accepted and must only
// arrive while the block is idle; a pixel_size written as zero acts as 480
// (30.0 map units).
module nearest_center_pixel_labeler #(
   parameter int MAX_IMAGES = 16,
   parameter int MAX_SIDE   = 4096
) (
   input  logic        clock,
   input  logic        reset,
   nclab_req_if.sink   req_chan,
   nclab_rsp_if.source rsp_chan,
   nclab_csr_if.sink   csr_chan
);
   import nclab_pkg::*;

   localparam int IDX_W = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
   localparam int CNT_W = $clog2(MAX_IMAGES + 1);

   // Configuration registers: count is stored saturated, size with the
   // zero substitution already applied
   logic [CNT_W-1:0]          count_ff;
   logic signed [COORD_W-1:0] origin_x_ff;
   logic signed [COORD_W-1:0] top_y_ff;
   logic [SIZE_W-1:0]         pixel_size_ff;
   logic [COUNT_W-1:0]        count_wr;

   cfg_type       cfg;
   req_data_type  req_data;
   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;
   logic [IDX_W-1:0] rd_addr;

   assign csr_chan.ready = 1'b1;
   assign count_wr       = csr_chan.data[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         origin_x_ff   <= '0;
         top_y_ff      <= '0;
         pixel_size_ff <= DEFAULT_PIXEL_SIZE;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_IMAGE_COUNT: begin
               if (int'(count_wr) > MAX_IMAGES) begin
                  count_ff <= CNT_W'(MAX_IMAGES);
               end else begin
                  count_ff <= CNT_W'(count_wr);
               end
            end
            CSR_ORIGIN_X: origin_x_ff <= csr_chan.data;
            CSR_TOP_Y:    top_y_ff    <= csr_chan.data;
            CSR_PIXEL_SIZE: begin
               if (csr_chan.data[SIZE_W-1:0] == '0) begin
                  pixel_size_ff <= DEFAULT_PIXEL_SIZE;
               end else begin
                  pixel_size_ff <= csr_chan.data[SIZE_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   assign cfg.origin_x   = origin_x_ff;
   assign cfg.top_y      = top_y_ff;
   assign cfg.pixel_size = pixel_size_ff;

   // Gather the request payload for the datapath
   assign req_data.entry_index = req_chan.entry_index;
   assign req_data.box_left    = req_chan.box_left;
   assign req_data.box_bottom  = req_chan.box_bottom;
   assign req_data.box_right   = req_chan.box_right;
   assign req_data.box_top     = req_chan.box_top;
   assign req_data.column      = req_chan.column;
   assign req_data.row         = req_chan.row;

   nclab_ctrl #(
      .MAX_IMAGES (MAX_IMAGES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_command (req_chan.command),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .count       (count_ff),
      .status      (dp_status),
      .cmd         (ctrl_cmd),
      .rd_addr     (rd_addr)
   );

   nclab_dp #(
      .MAX_IMAGES (MAX_IMAGES),
      .MAX_SIDE   (MAX_SIDE)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (ctrl_cmd),
      .status   (dp_status),
      .rd_addr  (rd_addr),
      .req_data (req_data),
      .cfg      (cfg),
      .label    (rsp_chan.label)
   );

`ifndef SYNTHESIS
   // A request transfer always takes the controller out of idle
   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted on back-to-back cycles");

   // Idle means the scan pipeline has drained
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !dp_status.pipe_busy)
      else $error("scan pipeline busy while accepting requests");

   // A label never names a slot beyond the table
   a_label_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (MAX_IMAGES >= 32 || int'(rsp_chan.label) <= MAX_IMAGES))
      else $error("label beyond table size");
`endif

endmodule
